### src/mst_pkg.sv
package mst_pkg;

  localparam int unsigned MaxAngles = 3;
  localparam int unsigned DefPolarAngles = 3;
  localparam int unsigned ExpBits = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CfgPolarWeight0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPolarWeight1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPolarWeight2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInverseSine0 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInverseSine1 = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgInverseSine2 = 3'd5;

  typedef struct packed {
    logic [15:0]        region;
    logic [30:0]        seg_length;
    logic [30:0]        sigma_total;
    logic [30:0]        source;
    logic [30:0]        track_weight;
    logic               first_of_track;
    logic               last_of_track;
    logic               exit_reflective;
    logic signed [31:0] entry_flux_0;
    logic signed [31:0] entry_flux_1;
    logic signed [31:0] entry_flux_2;
  } seg_in_t;

  typedef struct packed {
    logic [15:0]        region_out;
    logic signed [31:0] flux_increment;
    logic signed [31:0] exit_flux_0;
    logic signed [31:0] exit_flux_1;
    logic signed [31:0] exit_flux_2;
    logic               track_done;
  } seg_out_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SL    = 9'b000000010,
    ST_TAUHI = 9'b000000100,
    ST_TAULO = 9'b000001000,
    ST_EXP   = 9'b000010000,
    ST_DELTA = 9'b000100000,
    ST_WGT   = 9'b001000000,
    ST_ACC   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

  // exp(-2^(b-16)) in Q0.32
  function automatic logic [31:0] exp_factor(input logic [4:0] b);
    logic [31:0] v;
    case (b)
      5'd0:  v = 32'd4294901760;
      5'd1:  v = 32'd4294836226;
      5'd2:  v = 32'd4294705160;
      5'd3:  v = 32'd4294443040;
      5'd4:  v = 32'd4293918848;
      5'd5:  v = 32'd4292870656;
      5'd6:  v = 32'd4290775039;
      5'd7:  v = 32'd4286586875;
      5'd8:  v = 32'd4278222805;
      5'd9:  v = 32'd4261543595;
      5'd10: v = 32'd4228380000;
      5'd11: v = 32'd4162825044;
      5'd12: v = 32'd4034748382;
      5'd13: v = 32'd3790295335;
      5'd14: v = 32'd3344923893;
      5'd15: v = 32'd2605029347;
      5'd16: v = 32'd1580030169;
      5'd17: v = 32'd581260615;
      5'd18: v = 32'd78665070;
      5'd19: v = 32'd1440801;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -68'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

### src/moc_seg_in_if.sv
interface moc_seg_in_if;
  import mst_pkg::*;
  logic    valid;
  logic    ready;
  seg_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/moc_seg_out_if.sv
interface moc_seg_out_if;
  import mst_pkg::*;
  logic     valid;
  logic     ready;
  seg_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/moc_segment_transmission_sweep.sv
// Channel   | Dir | Payload   | Transaction
// seg_i     | in  | seg_in_t  | one track segment
// res_o     | out | seg_out_t | one flux increment, exit fluxes on last
// cfg_*     | in  | 31 bits   | one register write, no back-pressure
//
// One segment is worked through as products on the shared 34x34 multiplier, one
// product a cycle while the sequencer runs: a load, the path product, then per angle
// the two halves of tau, 20 exponent steps, delta, weight and sum; the first delta
// waits until the 48-step source / sigma divide ends; then a final and an idle state.
// The final state holds while the old result waits unaccepted in the output register.
// Reset clears control state, the fluxes and the polar weights, and sets each inverse sine to 65536.
module moc_segment_transmission_sweep #(
  parameter int unsigned POLAR_ANGLES = mst_pkg::DefPolarAngles
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  moc_seg_in_if.sink                    seg_i,
  moc_seg_out_if.source                 res_o,
  input  logic                          cfg_we_i,
  input  logic [mst_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mst_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mst_pkg::*;

  localparam logic [1:0] LastAngle = 2'(POLAR_ANGLES - 1);

  state_e             state_q, state_d;
  seg_in_t            seg_q;
  logic [30:0]        pw_q [MaxAngles];
  logic [30:0]        isin_q [MaxAngles];
  logic signed [31:0] psi_q [MaxAngles];
  logic [1:0]         ang_q;
  logic [46:0]        t1_q;
  logic [48:0]        prod_hi_q;
  logic [19:0]        tau_q;
  logic               long_q;
  logic [4:0]         bit_q;
  logic [31:0]        acc_q;
  logic               acc_one_q;
  logic signed [31:0] delta_q;
  logic [30:0]        w_q;
  logic signed [49:0] sum_q;
  logic               out_valid_q;
  seg_out_t           out_q;

  // Divider
  logic [31:0]        rem_q;
  logic [47:0]        quo_q;
  logic [5:0]         div_cnt_q;
  logic [31:0]        rem_sh;
  logic               div_bit;
  logic signed [31:0] ratio;

  logic               take;
  logic               out_free;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic [30:0]        isin_cur;
  logic [66:0]        tau_full;
  logic [50:0]        tau_w;
  logic [16:0]        exp_val;
  logic [16:0]        f_cur;
  logic signed [32:0] diff;
  logic signed [67:0] rnd;
  logic [63:0]        w_wide;

  assign seg_i.ready = (state_q == ST_IDLE);
  assign take        = seg_i.valid & seg_i.ready;
  assign out_free    = ~out_valid_q | res_o.ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;
  assign isin_cur    = isin_q[ang_q];

  // Shared multiplier: operands selected by sequencer state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SL: begin
        mul_a = {3'b0, seg_q.sigma_total};
        mul_b = {3'b0, seg_q.seg_length};
      end
      ST_TAUHI: begin
        mul_a = {16'b0, t1_q[35:18]};
        mul_b = {3'b0, isin_cur};
      end
      ST_TAULO: begin
        mul_a = {16'b0, t1_q[17:0]};
        mul_b = {3'b0, isin_cur};
      end
      ST_EXP: begin
        mul_a = {2'b0, acc_q};
        mul_b = {2'b0, exp_factor(bit_q)};
      end
      ST_DELTA: begin
        mul_a = 34'(diff);
        mul_b = {17'b0, f_cur};
      end
      ST_WGT: begin
        mul_a = {3'b0, seg_q.track_weight};
        mul_b = {3'b0, pw_q[ang_q]};
      end
      ST_ACC: begin
        mul_a = {3'b0, w_q};
        mul_b = 34'(delta_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign rnd      = (mul_p + 68'sd32768) >>> 16;
  assign tau_full = {prod_hi_q, 18'b0} + {18'b0, mul_p[48:0]};
  assign tau_w    = 51'(tau_full[66:16]) + 51'(tau_full[15]);
  assign exp_val  = acc_one_q ? 17'h10000 : 17'((33'(acc_q) + 33'd32768) >> 16);
  assign f_cur    = long_q ? 17'h10000 : 17'h10000 - exp_val;
  assign diff     = 33'(psi_q[ang_q]) - 33'(ratio);
  assign w_wide   = mul_p[63:0] + 64'd32768;

  // Restoring divide step
  assign rem_sh  = {rem_q[30:0], quo_q[47]};
  assign div_bit = rem_sh >= {1'b0, seg_q.sigma_total};
  assign ratio   = (seg_q.sigma_total == '0 || quo_q[47:31] != '0) ? 32'sh7FFFFFFF
                                                                  : 32'(quo_q[30:0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (take) state_d = ST_SL;
      ST_SL:    state_d = ST_TAUHI;
      ST_TAUHI: state_d = ST_TAULO;
      ST_TAULO: state_d = ST_EXP;
      ST_EXP:   if (bit_q == 5'(ExpBits - 1)) state_d = ST_DELTA;
      ST_DELTA: if (div_cnt_q == '0) state_d = ST_WGT;
      ST_WGT:   state_d = ST_ACC;
      ST_ACC:   state_d = (ang_q == LastAngle) ? ST_FIN : ST_TAUHI;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      ang_q       <= '0;
      for (int i = 0; i < MaxAngles; i++) begin
        pw_q[i]   <= '0;
        isin_q[i] <= 31'd65536;
        psi_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPolarWeight0: pw_q[0]   <= cfg_data_i;
          CfgPolarWeight1: pw_q[1]   <= cfg_data_i;
          CfgPolarWeight2: pw_q[2]   <= cfg_data_i;
          CfgInverseSine0: isin_q[0] <= cfg_data_i;
          CfgInverseSine1: isin_q[1] <= cfg_data_i;
          CfgInverseSine2: isin_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      // Raise valid for a fresh result, else drop it once the sink has taken it
      if (state_q == ST_FIN && out_free) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;

      // Divider advances on its own once loaded
      if (div_cnt_q != '0) begin
        rem_q     <= div_bit ? rem_sh - {1'b0, seg_q.sigma_total} : rem_sh;
        quo_q     <= {quo_q[46:0], div_bit};
        div_cnt_q <= div_cnt_q - 6'd1;
      end

      case (state_q)
        ST_IDLE: if (take) begin
          seg_q     <= seg_i.payload;
          ang_q     <= '0;
          sum_q     <= '0;
          rem_q     <= '0;
          quo_q     <= {1'b0, seg_i.payload.source, 16'b0}
                       + 48'(seg_i.payload.sigma_total >> 1);
          div_cnt_q <= 6'd48;
          if (seg_i.payload.first_of_track) begin
            psi_q[0] <= seg_i.payload.entry_flux_0;
            psi_q[1] <= seg_i.payload.entry_flux_1;
            psi_q[2] <= seg_i.payload.entry_flux_2;
          end
        end
        ST_SL: t1_q <= 47'((mul_p[61:0] + 62'd32768) >> 16);
        ST_TAUHI: prod_hi_q <= mul_p[48:0];
        ST_TAULO: begin
          // Long path when the product cannot stay below 16.0
          long_q    <= (isin_cur != '0 && t1_q[46:36] != '0) || tau_w[50:20] != '0;
          tau_q     <= tau_w[19:0];
          acc_q     <= '0;
          acc_one_q <= 1'b1;
          bit_q     <= '0;
        end
        ST_EXP: begin
          if (tau_q[bit_q]) begin
            if (acc_one_q) acc_q <= exp_factor(bit_q);
            else acc_q <= 32'((mul_p[63:0] + 64'h80000000) >> 32);
            acc_one_q <= 1'b0;
          end
          bit_q <= bit_q + 5'd1;
        end
        ST_DELTA: delta_q <= sat32(rnd);
        ST_WGT: w_q <= (w_wide[63:47] != '0) ? 31'h7FFFFFFF : w_wide[46:16];
        ST_ACC: begin
          sum_q        <= sum_q + rnd[49:0];
          psi_q[ang_q] <= sat32(68'(psi_q[ang_q]) - 68'(delta_q));
          ang_q        <= ang_q + 2'd1;
        end
        ST_FIN: if (out_free) begin
          out_q.region_out     <= seg_q.region;
          out_q.flux_increment <= sat32(68'(sum_q));
          out_q.exit_flux_0    <= (seg_q.last_of_track && seg_q.exit_reflective)
                                  ? psi_q[0] : '0;
          out_q.exit_flux_1    <= (seg_q.last_of_track && seg_q.exit_reflective
                                  && POLAR_ANGLES > 1) ? psi_q[1] : '0;
          out_q.exit_flux_2    <= (seg_q.last_of_track && seg_q.exit_reflective
                                  && POLAR_ANGLES > 2) ? psi_q[2] : '0;
          out_q.track_done     <= seg_q.last_of_track;
        end
        default: ;
      endcase
    end
  end

endmodule

### bench/moc_segment_transmission_sweep_test.sv
`timescale 1ns / 100ps

module moc_segment_transmission_sweep_test;
  import mst_pkg::*;

  // Receiver and sender idling schemes, one per phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // One stimulus row: the segment, the phase it belongs to and, where the
  // answer is plain to see, the result typed in by hand
  typedef struct {
    seg_in_t  seg;
    int       phase;
    bit       known;
    seg_out_t want;
  } seg_row_t;

  typedef struct {
    bit       known;
    seg_out_t want;
  } hand_result_t;

  localparam int unsigned WatchdogLimit = 40000;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned ItemsPerPhase = 138;
  localparam logic [30:0] Max31 = 31'h7FFFFFFF;
  localparam logic signed [31:0] FluxMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] FluxMin = 32'sh80000000;

  // exp(-2^(b-16)) in Q0.32, one factor per bit of the optical path
  localparam logic [31:0] ExpStep [20] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
    32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  logic clk;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  moc_seg_in_if  seg ();
  moc_seg_out_if res ();

  moc_segment_transmission_sweep dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .seg_i      (seg),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow of the block: register file and swept angular fluxes
  logic [30:0]        weight_reg [MaxAngles];
  logic [30:0]        inv_sine_reg [MaxAngles];
  logic signed [31:0] psi_state [MaxAngles];

  seg_out_t     result_due_q [$];
  hand_result_t hand_result_q [$];
  int           fail_count;
  int unsigned  quiet_cycles;
  int unsigned  stall_pct;
  seg_row_t     rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Attenuation 1 - exp(-tau) in Q16.16 for a Q16.16 path and 1/sine
  function automatic longint attenuation_of(input logic [63:0] path,
                                            input logic [30:0] inv_sine);
    logic [127:0] prod;
    logic [127:0] acc;
    logic [63:0]  tau;
    prod = {64'd0, path} * {97'd0, inv_sine};
    if (prod[127:64] != 0) return 64'sd65536;
    tau = 64'(prod[63:16]) + 64'(prod[15]);
    if (tau >= 64'd1048576) return 64'sd65536;
    acc = 128'd1 << 32;
    for (int b = 0; b < 20; b++) begin
      if (tau[b]) acc = (acc * {96'd0, ExpStep[b]} + 128'h80000000) >> 32;
    end
    return 64'sd65536 - longint'((acc + 128'd32768) >> 16);
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Sweep one segment through the shadow state and form its result
  function automatic seg_out_t sweep_segment(input seg_in_t s);
    seg_out_t   r;
    longint     ratio;
    longint     total;
    longint     atten;
    longint     psi;
    longint     delta;
    longint     w;
    logic [63:0] path;
    logic [63:0] quot;
    logic [63:0] wprod;
    total = 0;
    if (s.first_of_track) begin
      psi_state[0] = s.entry_flux_0;
      psi_state[1] = s.entry_flux_1;
      psi_state[2] = s.entry_flux_2;
    end
    // zero cross section saturates the source ratio
    if (s.sigma_total == 0) ratio = 64'sd2147483647;
    else begin
      quot = (({33'd0, s.source} << 16) + {33'd0, s.sigma_total >> 1})
             / {33'd0, s.sigma_total};
      ratio = (quot > 64'd2147483647) ? 64'sd2147483647 : longint'(quot);
    end
    path = ({33'd0, s.sigma_total} * {33'd0, s.seg_length} + 64'd32768) >> 16;
    for (int p = 0; p < MaxAngles; p++) begin
      atten = attenuation_of(path, inv_sine_reg[p]);
      psi = longint'(psi_state[p]);
      delta = clamp32(((psi - ratio) * atten + 64'sd32768) >>> 16);
      wprod = ({33'd0, s.track_weight} * {33'd0, weight_reg[p]} + 64'd32768) >> 16;
      w = (wprod > 64'd2147483647) ? 64'sd2147483647 : longint'(wprod);
      total += (w * delta + 64'sd32768) >>> 16;
      psi_state[p] = 32'(clamp32(psi - delta));
    end
    r.region_out = s.region;
    r.flux_increment = 32'(clamp32(total));
    // vacuum exit and inner segments hand out zero flux
    r.exit_flux_0 = (s.last_of_track && s.exit_reflective) ? psi_state[0] : '0;
    r.exit_flux_1 = (s.last_of_track && s.exit_reflective) ? psi_state[1] : '0;
    r.exit_flux_2 = (s.last_of_track && s.exit_reflective) ? psi_state[2] : '0;
    r.track_done = s.last_of_track;
    return r;
  endfunction

  function automatic seg_in_t make_seg(input logic [15:0] region, input logic [30:0] len,
                                       input logic [30:0] sig, input logic [30:0] src,
                                       input logic [30:0] tw, input logic first,
                                       input logic last, input logic refl,
                                       input logic [31:0] f0, input logic [31:0] f1,
                                       input logic [31:0] f2);
    seg_in_t s;
    s.region = region;
    s.seg_length = len;
    s.sigma_total = sig;
    s.source = src;
    s.track_weight = tw;
    s.first_of_track = first;
    s.last_of_track = last;
    s.exit_reflective = refl;
    s.entry_flux_0 = f0;
    s.entry_flux_1 = f1;
    s.entry_flux_2 = f2;
    return s;
  endfunction

  function automatic seg_out_t make_res(input logic [15:0] region, input logic [31:0] inc,
                                        input logic [31:0] e0, input logic [31:0] e1,
                                        input logic [31:0] e2, input logic done);
    seg_out_t r;
    r.region_out = region;
    r.flux_increment = inc;
    r.exit_flux_0 = e0;
    r.exit_flux_1 = e1;
    r.exit_flux_2 = e2;
    r.track_done = done;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, field, got, want);
    fail_count++;
  endtask

  // Log each accepted segment and queue the result it must produce
  always @(posedge clk) begin : seg_monitor
    seg_out_t     predicted;
    hand_result_t hand;
    if (rst_ni && seg.valid && seg.ready) begin
      predicted = sweep_segment(seg.payload);
      hand = hand_result_q.pop_front();
      result_due_q.insert(result_due_q.size(), hand.known ? hand.want : predicted);
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin : res_monitor
    seg_out_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (result_due_q.size() == 0) begin
        $display("%0t: result with none expected", $realtime);
        fail_count++;
      end else begin
        want = result_due_q.pop_front();
        if (res.payload.region_out !== want.region_out)
          report_mismatch("region_out", 32'(res.payload.region_out), 32'(want.region_out));
        if (res.payload.flux_increment !== want.flux_increment)
          report_mismatch("flux_increment", res.payload.flux_increment, want.flux_increment);
        if (res.payload.exit_flux_0 !== want.exit_flux_0)
          report_mismatch("exit_flux_0", res.payload.exit_flux_0, want.exit_flux_0);
        if (res.payload.exit_flux_1 !== want.exit_flux_1)
          report_mismatch("exit_flux_1", res.payload.exit_flux_1, want.exit_flux_1);
        if (res.payload.exit_flux_2 !== want.exit_flux_2)
          report_mismatch("exit_flux_2", res.payload.exit_flux_2, want.exit_flux_2);
        if (res.payload.track_done !== want.track_done)
          report_mismatch("track_done", 32'(res.payload.track_done), 32'(want.track_done));
      end
    end
  end

  // Receiver: stall at the rate the current phase asks
  always @(posedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: any stretch without a transaction on either channel is bounded
  always @(posedge clk) begin
    if (!rst_ni || (seg.valid && seg.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write all six registers back to back and mirror them in the shadow
  task automatic write_registers(input logic [30:0] w0, input logic [30:0] w1,
                                 input logic [30:0] w2, input logic [30:0] s0,
                                 input logic [30:0] s1, input logic [30:0] s2);
    logic [30:0] vals [6];
    logic [CfgIdxW-1:0] idx [6];
    vals = '{w0, w1, w2, s0, s1, s2};
    idx = '{CfgPolarWeight0, CfgPolarWeight1, CfgPolarWeight2,
            CfgInverseSine0, CfgInverseSine1, CfgInverseSine2};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      if (i < 3) weight_reg[i] = vals[i];
      else inv_sine_reg[i - 3] = vals[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain_results();
    seg.valid <= 1'b0;
    @(posedge clk);
    while (result_due_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_segment(input seg_in_t s, input bit known, input seg_out_t want,
                              input int unsigned idle_pct);
    hand_result_t hand;
    while ($urandom_range(0, 99) < idle_pct) begin
      seg.valid <= 1'b0;
      @(posedge clk);
    end
    hand.known = known;
    hand.want = want;
    hand_result_q.insert(hand_result_q.size(), hand);
    seg.valid <= 1'b1;
    seg.payload <= s;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_wide(input logic [30:0] typical_max);
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return '0;
      2: return Max31;
      default: return 31'($urandom_range(0, typical_max));
    endcase
  endfunction

  function automatic logic [31:0] pick_flux();
    case ($urandom_range(0, 7))
      0: return FluxMax;
      1: return FluxMin;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  initial begin : stimulus
    seg_out_t    none;
    seg_in_t     s;
    idle_mode_e  mode;
    int unsigned send_pct;
    int unsigned left;
    int unsigned track_len;
    logic [15:0] region;
    logic [30:0] sig;
    logic [30:0] src;
    logic [30:0] tw;
    logic        first;
    logic        last;
    logic        refl;
    int          cur_phase;

    none = '0;
    fail_count = 0;
    stall_pct = 0;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    seg.valid <= 1'b0;
    seg.payload <= '0;
    for (int p = 0; p < MaxAngles; p++) begin
      weight_reg[p] = '0;
      inv_sine_reg[p] = 31'd65536;
      psi_state[p] = '0;
    end
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed rows. Phase 0 runs on reset registers: zero weights give no
    // increment, and a zero path length leaves the fluxes untouched.
    rows.insert(rows.size(), '{make_seg(16'h0000, '0, 31'd1, '0, Max31, 1'b1, 1'b1, 1'b0,
                                         FluxMax, FluxMin, FluxMax), 0, 1'b1,
                               make_res(16'h0000, '0, '0, '0, '0, 1'b1)});
    rows.insert(rows.size(), '{make_seg(16'hFFFF, Max31, Max31, Max31, Max31,
                                         1'b0, 1'b0, 1'b1, '0, '0, '0), 0, 1'b1,
                               make_res(16'hFFFF, '0, '0, '0, '0, 1'b0)});
    rows.insert(rows.size(), '{make_seg(16'h1234, '0, Max31, Max31, Max31, 1'b1, 1'b1, 1'b1,
                                         FluxMax, FluxMin, 32'h12345678), 0, 1'b1,
                               make_res(16'h1234, '0, FluxMax, FluxMin, 32'h12345678,
                                        1'b1)});
    rows.insert(rows.size(), '{make_seg(16'h0001, '0, '0, Max31, '0, 1'b1, 1'b1, 1'b1,
                                         FluxMin, '0, FluxMax), 0, 1'b1,
                               make_res(16'h0001, '0, FluxMin, '0, FluxMax, 1'b1)});
    // Phase 1: realistic weights and sines; the predictor decides
    rows.insert(rows.size(), '{make_seg(16'h0002, 31'h10000, 31'h8000, 31'h20000, 31'h10000,
                                         1'b1, 1'b0, 1'b1, 32'h00050000, 32'h00020000,
                                         32'hFFFF0000), 1, 1'b0, none});
    // missing first: carry on from stored fluxes
    rows.insert(rows.size(), '{make_seg(16'h0003, 31'h4000, 31'h18000, 31'h8000, 31'h10000,
                                         1'b0, 1'b0, 1'b1, FluxMax, FluxMax, FluxMax),
                               1, 1'b0, none});
    // reflective exit
    rows.insert(rows.size(), '{make_seg(16'h0004, 31'h2000, 31'h10000, 31'h10000, 31'h10000,
                                         1'b0, 1'b1, 1'b1, '0, '0, '0), 1, 1'b0, none});
    // missing first after a finished track, vacuum exit
    rows.insert(rows.size(), '{make_seg(16'h0005, 31'h20000, 31'h10000, '0, 31'h10000,
                                         1'b0, 1'b1, 1'b0, '0, '0, '0), 1, 1'b0, none});
    // long path: tau well beyond 16
    rows.insert(rows.size(), '{make_seg(16'h0006, Max31, Max31, 31'h10000, Max31,
                                         1'b1, 1'b1, 1'b1, FluxMax, FluxMin, '0),
                               1, 1'b0, none});
    // long path right at 16.0
    rows.insert(rows.size(), '{make_seg(16'h0007, 31'h40000, 31'h40000, 31'h10000, 31'h10000,
                                         1'b1, 1'b1, 1'b1, 32'h00100000, 32'h00100000,
                                         32'h00100000), 1, 1'b0, none});
    // zero cross section with large source and negative flux
    rows.insert(rows.size(), '{make_seg(16'h0008, 31'h10000, '0, Max31, 31'h10000,
                                         1'b1, 1'b1, 1'b1, FluxMin, FluxMin, FluxMin),
                               1, 1'b0, none});
    // saturating increment: huge weights and deltas
    rows.insert(rows.size(), '{make_seg(16'h0009, 31'h80000, 31'h80000, '0, Max31,
                                         1'b1, 1'b1, 1'b1, FluxMax, FluxMax, FluxMax),
                               1, 1'b0, none});
    rows.insert(rows.size(), '{make_seg(16'h000A, 31'h8000, 31'h8000, Max31, Max31,
                                         1'b1, 1'b1, 1'b1, FluxMin, FluxMin, FluxMin),
                               1, 1'b0, none});
    // smallest cross section, largest length
    rows.insert(rows.size(), '{make_seg(16'hFFFF, Max31, 31'd1, 31'd1, 31'd1,
                                         1'b1, 1'b1, 1'b1, 32'd1, 32'hFFFFFFFF, 32'd0),
                               1, 1'b0, none});

    cur_phase = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != cur_phase) begin
        drain_results();
        write_registers(31'h000C0000, 31'h00080000, 31'h00040000,
                        31'h00010000, 31'h00018000, 31'h00030000);
        cur_phase = rows[i].phase;
      end
      send_segment(rows[i].seg, rows[i].known, rows[i].want, 0);
    end

    // Random phases: each a fresh register setting and an idling scheme.
    // Most items form proper tracks; a few carry stray first/last flags.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_results();
      case (ph)
        0: write_registers(Max31, Max31, Max31, '0, '0, '0);
        1: write_registers('0, '0, '0, Max31, Max31, Max31);
        2: write_registers(31'($urandom), 31'($urandom), 31'($urandom),
                           31'($urandom), 31'($urandom), 31'($urandom));
        default: write_registers(31'($urandom_range(0, 1 << 20)),
                                 31'($urandom_range(0, 1 << 20)),
                                 31'($urandom_range(0, 1 << 20)),
                                 31'($urandom_range(1 << 16, 3 << 16)),
                                 31'($urandom_range(1 << 16, 3 << 16)),
                                 31'($urandom_range(1 << 16, 3 << 16)));
      endcase
      mode = idle_mode_e'(ph % 4);
      send_pct = (mode == IDLE_SEND) ? 47 : (mode == IDLE_BOTH) ? 28 : 0;
      stall_pct = (mode == IDLE_RECV) ? 47 : (mode == IDLE_BOTH) ? 28 : 0;
      left = ItemsPerPhase;
      while (left > 0) begin
        track_len = $urandom_range(1, 6);
        region = 16'($urandom);
        // pause mid-run in phase 2 until everything is back
        if (ph == 2 && left < ItemsPerPhase / 2 && left + 6 >= ItemsPerPhase / 2)
          drain_results();
        for (int k = 0; k < track_len && left > 0; k++) begin
          first = (k == 0);
          last = (k == track_len - 1) || (left == 1);
          refl = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 99) < 15) begin
            first = 1'($urandom_range(0, 1));
            last = 1'($urandom_range(0, 1));
          end
          sig = ($urandom_range(0, 19) == 0) ? '0 : pick_wide(31'h20000);
          src = pick_wide(31'h100000);
          tw = pick_wide(31'h20000);
          s = make_seg(($urandom_range(0, 3) == 0) ? 16'($urandom) : region,
                       pick_wide(31'h20000), sig, src, tw, first, last, refl,
                       pick_flux(), pick_flux(), pick_flux());
          send_segment(s, 1'b0, none, send_pct);
          left--;
        end
      end
    end

    // Wind down: everything back, then let the block go quiet
    seg.valid <= 1'b0;
    @(posedge clk);
    while (result_due_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
